FILE: hdl/ptr_pkg.sv
// Shared types, register indexes and constants for the programmable timer.
// Used by ptr_engine, programmable_timer_with_reload and ptr_checker; depends on nothing.
package ptr_pkg;

  localparam int unsigned ELAPSED_W = 10;
  localparam int unsigned SCALED_W  = 11;
  localparam int unsigned PRESC_W   = 16;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned TOTAL_W   = 9;
  localparam int unsigned DIST_W    = 19;
  localparam int unsigned SHIFT_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [PRESC_W-1:0] MAX_ELAPSED = 16'd1023;
  localparam logic [TOTAL_W-1:0] COUNT_WRAP  = 9'h100;
  localparam logic [TOTAL_W-1:0] COUNT_TOP   = 9'h0ff;
  localparam logic [COUNT_W-1:0] IRQ_MAX     = 8'hff;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_SELECT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD_VALUE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_MODE    = 2'd3;

  localparam logic [1:0] SEL_1024 = 2'd0;
  localparam logic [1:0] SEL_16   = 2'd1;
  localparam logic [1:0] SEL_64   = 2'd2;
  localparam logic [1:0] SEL_256  = 2'd3;

  typedef struct packed {
    logic               enable;
    logic [1:0]         clock_select;
    logic [COUNT_W-1:0] reload_value;
    logic               fast_mode;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0] counter_value;
    logic [COUNT_W-1:0] irq_count;
    logic               next_valid;
    logic [DIST_W-1:0]  cycles_to_overflow;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOP = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  function automatic logic [SHIFT_W-1:0] period_shift(input logic [1:0] sel);
    logic [SHIFT_W-1:0] sh;
    case (sel)
      SEL_1024: sh = 4'd10;
      SEL_16:   sh = 4'd4;
      SEL_64:   sh = 4'd6;
      SEL_256:  sh = 4'd8;
      default:  sh = 4'd10;
    endcase
    return sh;
  endfunction

endpackage

FILE: hdl/ptr_engine.sv
// Timer sequencer: divider, tick count, iterative overflow reload and result register.
// Depends on ptr_pkg.
module ptr_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ptr_pkg::cfg_t                       cfg,
  input  logic                                in_valid,
  input  logic [ptr_pkg::ELAPSED_W-1:0]       in_elapsed,
  output logic                                in_stall,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ptr_pkg::res_t                       res
);

  ptr_pkg::state_t                 state_r, state_nxt;
  logic [ptr_pkg::PRESC_W-1:0]     presc_r, presc_nxt;
  logic [ptr_pkg::COUNT_W-1:0]     timer_r, timer_nxt;
  logic [ptr_pkg::TOTAL_W-1:0]     total_r, total_nxt;
  logic [ptr_pkg::COUNT_W-1:0]     irq_r, irq_nxt;
  logic                            out_valid_r, out_valid_nxt;
  ptr_pkg::res_t                   res_r, res_nxt;

  logic [ptr_pkg::SHIFT_W-1:0]     shift;
  logic [ptr_pkg::PRESC_W-1:0]     mask;
  logic [ptr_pkg::ELAPSED_W-1:0]   sat;
  logic [ptr_pkg::SCALED_W-1:0]    scaled;
  logic [ptr_pkg::SCALED_W:0]      phase_sum;
  logic [ptr_pkg::SCALED_W:0]      ticks;
  logic [ptr_pkg::TOTAL_W-1:0]     drop;
  logic [ptr_pkg::DIST_W-1:0]      dist_full;
  logic [ptr_pkg::DIST_W-1:0]      ovf_dist;
  logic                            accept;
  logic                            out_free;

  assign shift    = ptr_pkg::period_shift(cfg.clock_select);
  assign mask     = (ptr_pkg::PRESC_W'(1) << shift) - ptr_pkg::PRESC_W'(1);
  assign sat      = ({{(ptr_pkg::PRESC_W-ptr_pkg::ELAPSED_W){1'b0}}, in_elapsed}
                     > ptr_pkg::MAX_ELAPSED) ?
                    ptr_pkg::MAX_ELAPSED[ptr_pkg::ELAPSED_W-1:0] : in_elapsed;
  assign scaled   = {1'b0, sat} << cfg.fast_mode;
  assign phase_sum = {1'b0, scaled} + (presc_r[ptr_pkg::SCALED_W:0] &
                                       mask[ptr_pkg::SCALED_W:0]);
  assign ticks    = phase_sum >> shift;
  assign drop     = ptr_pkg::COUNT_WRAP - {1'b0, cfg.reload_value};
  assign dist_full = ((ptr_pkg::DIST_W'(ptr_pkg::COUNT_WRAP) -
                       ptr_pkg::DIST_W'(total_r[ptr_pkg::COUNT_W-1:0])) << shift) -
                     ptr_pkg::DIST_W'(presc_r & mask);
  assign ovf_dist = dist_full >> cfg.fast_mode;

  assign accept   = in_valid && (state_r == ptr_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    presc_nxt     = presc_r;
    timer_nxt     = timer_r;
    total_nxt     = total_r;
    irq_nxt       = irq_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ptr_pkg::ST_IDLE: begin
        if (accept) begin
          presc_nxt = presc_r + ptr_pkg::PRESC_W'(scaled);
          total_nxt = ptr_pkg::TOTAL_W'(ticks) + {1'b0, timer_r};
          irq_nxt   = '0;
          state_nxt = cfg.enable ? ptr_pkg::ST_LOOP : ptr_pkg::ST_DONE;
        end
      end
      ptr_pkg::ST_LOOP: begin
        if (total_r > ptr_pkg::COUNT_TOP) begin
          total_nxt = total_r - drop;
          if (irq_r != ptr_pkg::IRQ_MAX) begin
            irq_nxt = irq_r + 1'b1;
          end
        end else begin
          state_nxt = ptr_pkg::ST_DONE;
        end
      end
      ptr_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (cfg.enable) begin
            timer_nxt                  = total_r[ptr_pkg::COUNT_W-1:0];
            res_nxt.counter_value      = total_r[ptr_pkg::COUNT_W-1:0];
            res_nxt.irq_count          = irq_r;
            res_nxt.next_valid         = 1'b1;
            res_nxt.cycles_to_overflow = ovf_dist;
          end else begin
            res_nxt.counter_value      = timer_r;
            res_nxt.irq_count          = '0;
            res_nxt.next_valid         = 1'b0;
            res_nxt.cycles_to_overflow = '0;
          end
          state_nxt = ptr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ptr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptr_pkg::ST_IDLE;
      presc_r     <= '0;
      timer_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      presc_r     <= presc_nxt;
      timer_r     <= timer_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
    irq_r   <= irq_nxt;
    res_r   <= res_nxt;
  end

  assign in_stall  = (state_r != ptr_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

FILE: hdl/programmable_timer_with_reload.sv
// Top level of the prescaled 8-bit timer with modulo reload.
// Holds the control registers; depends on ptr_pkg and ptr_engine.
// Usage:
//   Input channel (in_valid/in_stall/in_elapsed_cycles): one word per sync,
//   giving machine cycles elapsed since the previous word.
//   Result channel (out_valid/out_stall/out_*): one word per input word with
//   the counter, overflow count and cycles to the next overflow.
//   Control port (cfg_we/cfg_index/cfg_wdata): write enable, control, reload
//   and fast-mode registers while no word is in flight.
// Timing:
//   An accepted word steps through ST_LOOP, one reload subtraction per cycle for
//   each of its N overflows (up to 128), and then ST_DONE; a disabled timer
//   goes straight to ST_DONE. in_stall stays high until the result is
//   registered, so a new word waits until the previous one is finished.
// Reset:
//   Synchronous, active low; clears divider, counter and control registers
//   (prescaler 1024, timer off) and drops out_valid.
// Stall:
//   A stalled result holds in the output register; the next word may be
//   accepted meanwhile and waits in its final step until the register frees.
module programmable_timer_with_reload (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ptr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptr_pkg::CFG_DAT_W-1:0]     cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ptr_pkg::ELAPSED_W-1:0]     in_elapsed_cycles,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ptr_pkg::COUNT_W-1:0]       out_counter_value,
  output logic [ptr_pkg::COUNT_W-1:0]       out_irq_count,
  output logic                              out_next_valid,
  output logic [ptr_pkg::DIST_W-1:0]        out_cycles_to_overflow
);

  ptr_pkg::cfg_t cfg_r, cfg_nxt;
  ptr_pkg::res_t res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        ptr_pkg::REG_ENABLE:       cfg_nxt.enable       = cfg_wdata[0];
        ptr_pkg::REG_CLOCK_SELECT: cfg_nxt.clock_select = cfg_wdata[1:0];
        ptr_pkg::REG_RELOAD_VALUE: cfg_nxt.reload_value = cfg_wdata;
        ptr_pkg::REG_FAST_MODE:    cfg_nxt.fast_mode    = cfg_wdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ptr_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_elapsed (in_elapsed_cycles),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res        (res)
  );

  assign out_counter_value      = res.counter_value;
  assign out_irq_count          = res.irq_count;
  assign out_next_valid         = res.next_valid;
  assign out_cycles_to_overflow = res.cycles_to_overflow;

endmodule

FILE: hdl/ptr_checker.sv
// Port-level checks for programmable_timer_with_reload, with the bind that attaches them.
// Depends on ptr_pkg and the top level's ports.
module ptr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [ptr_pkg::COUNT_W-1:0]       out_counter_value,
  input logic [ptr_pkg::COUNT_W-1:0]       out_irq_count,
  input logic                              out_next_valid,
  input logic [ptr_pkg::DIST_W-1:0]        out_cycles_to_overflow
);

  a_reset_drop: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new word taken while previous word still in work");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_counter_value) &&
      $stable(out_irq_count) && $stable(out_next_valid) &&
      $stable(out_cycles_to_overflow))
    else $error("stalled result word changed");

  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_next_valid |-> out_irq_count == '0 && out_cycles_to_overflow == '0)
    else $error("disabled timer reported overflow data");

endmodule

bind programmable_timer_with_reload ptr_checker u_ptr_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_stall               (in_stall),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_counter_value      (out_counter_value),
  .out_irq_count          (out_irq_count),
  .out_next_valid         (out_next_valid),
  .out_cycles_to_overflow (out_cycles_to_overflow)
);
